>>> sv/aes_ctr_pkg.sv
package aes_ctr_pkg;

  typedef struct packed {
    logic        restart;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  out_count;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_KEY_HIGH   = 2'd0,
    REG_KEY_LOW    = 2'd1,
    REG_NONCE_HIGH = 2'd2,
    REG_NONCE_LOW  = 2'd3
  } cfg_reg_t;

  localparam logic [3:0] LAST_ROUND = 4'd10;
  localparam logic [4:0] BLOCK_BYTES = 5'd16;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] rcon(input logic [3:0] rnd);
    case (rnd)
      4'd1:    rcon = 32'h01000000;
      4'd2:    rcon = 32'h02000000;
      4'd3:    rcon = 32'h04000000;
      4'd4:    rcon = 32'h08000000;
      4'd5:    rcon = 32'h10000000;
      4'd6:    rcon = 32'h20000000;
      4'd7:    rcon = 32'h40000000;
      4'd8:    rcon = 32'h80000000;
      4'd9:    rcon = 32'h1b000000;
      4'd10:   rcon = 32'h36000000;
      default: rcon = 32'h00000000;
    endcase
  endfunction

  // next round key from the previous one, word 0 in the top bits
  function automatic logic [127:0] next_round_key(input logic [127:0] k, input logic [3:0] rnd);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[127:96] ^ sub_word({k[23:0], k[31:24]}) ^ rcon(rnd);
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    next_round_key = {w0, w1, w2, w3};
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    mix_column = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                  a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                  a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                  xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // byte i of the state sits at bits 127-8i downto 120-8i
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8 * (4 * c + i) -: 8] = SBOX[s[127 - 8 * (4 * ((c + i) % 4) + i) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[127 - 32 * c -: 32] = mix_column(t[127 - 32 * c -: 32]);
    end
    aes_round = (last ? t : m) ^ rk;
  endfunction

endpackage

>>> sv/aes128_ctr_block_cipher.sv
// AES-128 counter mode cipher, one 16-byte item at a time.
// in channel: in_valid/in_stall with an in_item_t payload. restart=1 reloads
// the counter from nonce bytes 12..15 and latches the key registers as the
// round-0 key. Nonce bytes 0..11 are used live. byte_count above 16 is taken
// as 16; bytes at and past the count come out as zero.
// out channel: out_valid/out_stall with an out_item_t payload held in an
// output register until taken.
// cfg channel: cfg_valid/cfg_ready (ready always high), cfg_index selects
// key_high, key_low, nonce_high, nonce_low. Write only while idle.
// Timing: one shared round unit runs one AES round per cycle with the round
// key computed alongside it. The initial key addition happens in the accept
// cycle; the last round is computed straight into the output register, and
// the block goes idle in the same cycle that the result appears. It takes no
// new item before it is through with the last one.
// If the result register is still full at the last round, the block holds
// there until the receiver takes the earlier result.
// Reset: counter clears to zero, state goes idle, output empties. Key and
// nonce registers clear to zero.
module aes128_ctr_block_cipher
  import aes_ctr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ROUND = 2'b10
  } state_t;

  state_t       state_r, state_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [63:0]  key_high_r, key_low_r, nonce_high_r, nonce_low_r;
  logic [31:0]  ctr_r, ctr_nxt;
  logic [127:0] key_r;
  logic [127:0] rk_r;
  logic [127:0] s_r;
  logic [127:0] data_r;
  logic [4:0]   cnt_r;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_r;

  logic         in_acc;
  logic [31:0]  ctr_use;
  logic [127:0] key_use;
  logic [127:0] ctr_blk;
  logic [4:0]   cnt_sat;
  logic [127:0] rk_nxt;
  logic [127:0] s_nxt;
  logic [127:0] res;
  logic         finish;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r   <= '0;
      key_low_r    <= '0;
      nonce_high_r <= '0;
      nonce_low_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_HIGH:   key_high_r   <= cfg_data;
        REG_KEY_LOW:    key_low_r    <= cfg_data;
        REG_NONCE_HIGH: nonce_high_r <= cfg_data;
        REG_NONCE_LOW:  nonce_low_r  <= cfg_data;
        default:        key_high_r   <= key_high_r;
      endcase
    end
  end

  // counter byte 12 is the counter's low byte
  always_comb begin
    ctr_use = in_item.restart ? {nonce_low_r[7:0], nonce_low_r[15:8], nonce_low_r[23:16],
                                 nonce_low_r[31:24]} : ctr_r;
    key_use = in_item.restart ? {key_high_r, key_low_r} : key_r;
    ctr_blk = {nonce_high_r, nonce_low_r[63:32],
               ctr_use[7:0], ctr_use[15:8], ctr_use[23:16], ctr_use[31:24]};
    cnt_sat = (in_item.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : in_item.byte_count;
    ctr_nxt = in_acc ? ctr_use + 32'd1 : ctr_r;
  end

  assign rk_nxt = next_round_key(rk_r, rnd_r);
  assign s_nxt  = aes_round(s_r, rk_nxt, rnd_r == LAST_ROUND);
  assign finish = (state_r == ST_ROUND) && (rnd_r == LAST_ROUND) && !(out_valid_r && out_stall);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      res[127 - 8 * i -: 8] = (5'(i) < cnt_r) ?
                              (s_nxt[127 - 8 * i -: 8] ^ data_r[127 - 8 * i -: 8]) : 8'h00;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_ROUND;
          rnd_nxt   = 4'd1;
        end
      end
      ST_ROUND: begin
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else if (rnd_r != LAST_ROUND) begin
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r  <= key_use;
      rk_r   <= key_use;
      s_r    <= ctr_blk ^ key_use;
      data_r <= {in_item.block_high, in_item.block_low};
      cnt_r  <= cnt_sat;
    end else if (state_r == ST_ROUND && rnd_r != LAST_ROUND) begin
      rk_r <= rk_nxt;
      s_r  <= s_nxt;
    end
    if (finish) begin
      out_r.out_high  <= res[127:64];
      out_r.out_low   <= res[63:0];
      out_r.out_count <= cnt_r;
    end
  end

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> (rnd_r >= 4'd1 && rnd_r <= LAST_ROUND))
    else $error("round index out of range");
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_ROUND && rnd_r == LAST_ROUND))
    else $error("result without a finished last round");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_ROUND && rnd_r == 4'd1))
    else $error("accept did not start the rounds");
  a_round_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r != LAST_ROUND) |=> (rnd_r == $past(rnd_r) + 4'd1))
    else $error("round counter skipped");
`endif

endmodule

>>> verif/tb_aes128_ctr_block_cipher.sv
`timescale 1ns / 100ps

module tb_aes128_ctr_block_cipher;
  import aes_ctr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // s-box built at time zero from the multiplicative inverse and affine map
  logic [7:0] sbox_tab [0:255];

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] affine(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++)
      r[i] = v[i] ^ v[(i + 4) % 8] ^ v[(i + 5) % 8] ^ v[(i + 6) % 8] ^ v[(i + 7) % 8];
    return r ^ 8'h63;
  endfunction

  initial begin
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      sbox_tab[x] = affine(inv);
    end
  end

  class ctr_scoreboard;
    logic [63:0] key_hi, key_lo, nonce_hi, nonce_lo;
    logic [31:0] ctr;
    logic [31:0] rk [0:43];
    out_item_t pending_q[$];
    int mismatches;
    int checked;

    function new();
      key_hi = '0; key_lo = '0; nonce_hi = '0; nonce_lo = '0; ctr = '0;
      mismatches = 0; checked = 0;
      for (int i = 0; i < 44; i++) rk[i] = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [63:0] v);
      case (idx)
        REG_KEY_HIGH:   key_hi = v;
        REG_KEY_LOW:    key_lo = v;
        REG_NONCE_HIGH: nonce_hi = v;
        REG_NONCE_LOW:  nonce_lo = v;
        default:        ;
      endcase
    endfunction

    function logic [31:0] sw(logic [31:0] w);
      return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
    endfunction

    function void expand();
      logic [31:0] t;
      logic [31:0] rc;
      logic [127:0] k;
      k = {key_hi, key_lo};
      for (int i = 0; i < 4; i++) rk[i] = k[127 - 32 * i -: 32];
      rc = 32'h01000000;
      for (int i = 4; i < 44; i++) begin
        t = rk[i - 1];
        if (i % 4 == 0) begin
          t = sw({t[23:0], t[31:24]}) ^ rc;
          rc = {gf_dbl(rc[31:24]), 24'h0};
        end
        rk[i] = rk[i - 4] ^ t;
      end
    endfunction

    // bytes indexed 0..15, byte 0 at the top
    function logic [127:0] keystream(logic [127:0] blk);
      logic [7:0] s [0:15];
      logic [7:0] t [0:15];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] r;
      for (int i = 0; i < 16; i++)
        s[i] = blk[127 - 8 * i -: 8] ^ rk[i / 4][31 - 8 * (i % 4) -: 8];
      for (int rnd = 1; rnd <= 10; rnd++) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++)
            t[4 * c + i] = sbox_tab[s[4 * ((c + i) % 4) + i]];
        for (int c = 0; c < 4; c++) begin
          a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
          if (rnd < 10) begin
            s[4 * c]     = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
            s[4 * c + 1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
            s[4 * c + 2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
            s[4 * c + 3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
          end else begin
            s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
          end
        end
        for (int i = 0; i < 16; i++)
          s[i] ^= rk[4 * rnd + i / 4][31 - 8 * (i % 4) -: 8];
      end
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
      return r;
    endfunction

    function void note_input(in_item_t it);
      logic [127:0] cb, ks, data, res;
      int n;
      out_item_t e;
      if (it.restart) begin
        ctr = {nonce_lo[7:0], nonce_lo[15:8], nonce_lo[23:16], nonce_lo[31:24]};
        expand();
      end
      n = (it.byte_count > 16) ? 16 : it.byte_count;
      cb = {nonce_hi, nonce_lo[63:32], ctr[7:0], ctr[15:8], ctr[23:16], ctr[31:24]};
      ks = keystream(cb);
      ctr = ctr + 32'd1;
      data = {it.block_high, it.block_low};
      for (int i = 0; i < 16; i++)
        res[127 - 8 * i -: 8] = (i < n) ? (data[127 - 8 * i -: 8] ^ ks[127 - 8 * i -: 8]) : 8'h00;
      e.out_high = res[127:64];
      e.out_low = res[63:0];
      e.out_count = n[4:0];
      pending_q.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %h", got);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.out_high !== e.out_high || got.out_low !== e.out_low ||
          got.out_count !== e.out_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h %h %0d, got %h %h %0d", e.out_high, e.out_low,
                   e.out_count, got.out_high, got.out_low, got.out_count);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_item;
  out_item_t out_item;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;

  aes128_ctr_block_cipher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ctr_scoreboard sb = new();
  int cycles = 0;
  int stall_pct = 20;
  int gap_pct = 20;
  int restarts = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_valid = 1'b0; in_item = '0; out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  task automatic write_cfg(cfg_reg_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic rs, logic [63:0] hi, logic [63:0] lo, logic [4:0] cnt);
    in_item_t it;
    it.restart = rs; it.block_high = hi; it.block_low = lo; it.byte_count = cnt;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    if (rs) restarts++;
    @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic configure(logic [63:0] kh, logic [63:0] kl, logic [63:0] nh,
                           logic [63:0] nl);
    drain();
    write_cfg(REG_KEY_HIGH, kh);
    write_cfg(REG_KEY_LOW, kl);
    write_cfg(REG_NONCE_HIGH, nh);
    write_cfg(REG_NONCE_LOW, nl);
  endtask

  initial begin
    int msg_len;
    wait (rst_n === 1'b1);
    // standard test vector key, counter near wrap
    configure(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'hf0f1f2f3f4f5f6f7,
              64'hf8f9fafbfeffffff);
    send_item(1'b1, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16);
    for (int i = 0; i < 3; i++) send_item(1'b0, '1, '1, 5'd16);
    send_item(1'b0, '0, '0, 5'd0);
    send_item(1'b0, '1, '1, 5'd1);
    send_item(1'b0, '1, '1, 5'd31);
    send_item(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd17);
    send_item(1'b0, '1, '1, 5'd15);
    send_item(1'b0, '1, '1, 5'd8);
    send_item(1'b0, '1, '1, 5'd9);
    // all-zero and all-one settings; nonce bytes 0..11 changed without restart
    configure('0, '0, '0, '0);
    send_item(1'b1, '0, '0, 5'd16);
    send_item(1'b0, '1, '0, 5'd16);
    configure('1, '1, '1, '1);
    send_item(1'b0, '0, '1, 5'd16);
    send_item(1'b1, '1, '1, 5'd16);
    send_item(1'b0, '0, '0, 5'd16);
    send_item(1'b0, rand64(), rand64(), 5'd12);

    // messages: restart then random-length run of blocks
    for (int n = 0; n < 1380; ) begin
      if (n == 400) begin
        stall_pct = 0; gap_pct = 0;
      end
      if (n == 600) begin
        stall_pct = 20; gap_pct = 20;
      end
      if (n % 300 < 20 && $urandom_range(3) == 0) begin
        configure(rand64(), rand64(), rand64(),
                  ($urandom_range(1) ? rand64() : {$urandom(), 32'hfdffffff}));
      end
      if (n == 900) drain();
      msg_len = $urandom_range(1, 12);
      for (int j = 0; j < msg_len; j++) begin
        send_item(j == 0 ? 1'b1 : ($urandom_range(30) == 0), rand64(), rand64(),
                  ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'd16);
        n++;
      end
    end

    drain();
    $display("checked %0d result items, %0d restarts, key/nonce varied incl. all-0 and all-1",
             sb.checked, restarts);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/aes_ctr_pkg.sv
sv/aes128_ctr_block_cipher.sv
verif/tb_aes128_ctr_block_cipher.sv
